/* rtl/emap_pkg.sv */
// Package for the extent map lookup block: request, response, table entry and compare result
// types, command codes and node constants. No dependencies.
`timescale 1ns / 1ps

package emap_pkg;

	localparam int MAX_ENTRIES_DEF = 512;
	localparam int ENTRY_BYTES = 12;
	localparam int ENTRY_BITS = ENTRY_BYTES * 8;
	localparam logic [15:0] NODE_MAGIC_OK = 16'hF30A;

	localparam logic [1:0] CMD_LOAD_HDR = 2'd0;
	localparam logic [1:0] CMD_LOAD_ENTRY = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [8:0]  slot;
		logic [15:0] hdr_magic;
		logic [15:0] hdr_count;
		logic [15:0] hdr_depth;
		logic [31:0] entry_first;
		logic [15:0] entry_len;
		logic [47:0] entry_target;
		logic [31:0] query_block;
	} req_t;

	typedef struct packed {
		logic [48:0] mapped_block;
		logic        found;
		logic        is_child;
	} rsp_t;

	// One stored entry, packed to the on-disk entry size.
	typedef struct packed {
		logic [31:0] first;
		logic [15:0] len;
		logic [47:0] target;
	} entry_t;

	// Result of checking one entry against the queried block.
	typedef struct packed {
		logic        leaf_hit;
		logic        past;
		logic [31:0] offset;
	} cmp_t;

endpackage

/* rtl/emap_table.sv */
// Entry table of the extent map lookup block: one write port, one registered read port.
// Depends on emap_pkg.
`timescale 1ns / 1ps

module emap_table #(
	parameter int MaxEntries = emap_pkg::MAX_ENTRIES_DEF,
	localparam int AW = $clog2(MaxEntries)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  emap_pkg::entry_t wdata,
	input  logic [AW-1:0]    raddr,
	output emap_pkg::entry_t rdata
);
	import emap_pkg::*;

	logic [ENTRY_BITS-1:0] mem [MaxEntries];
	logic [ENTRY_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = entry_t'(rdata_q);

endmodule

/* rtl/emap_cmp.sv */
// Shared compare unit: checks one table entry against the queried block.
// Depends on emap_pkg.
`timescale 1ns / 1ps

module emap_cmp (
	input  emap_pkg::entry_t entry,
	input  logic [31:0]      query,
	output emap_pkg::cmp_t   res
);
	import emap_pkg::*;

	logic [31:0] range_end;

	// The range end wraps modulo 2^32, so a wrapped extent covers nothing.
	assign range_end = entry.first + {16'd0, entry.len};

	always_comb begin
		res.leaf_hit = (query >= entry.first) && (query < range_end);
		res.past = entry.first > query;
		res.offset = query - entry.first;
	end

endmodule

/* rtl/extent_map_lookup.sv */
// Top level of the extent map lookup block: command decode, header registers and the
// scan sequencer. Depends on emap_pkg, emap_table and emap_cmp.
`timescale 1ns / 1ps

// A command transfers when start is high and busy is low. Header and entry loads give no
// result. A lookup scans the stored entries one per cycle through the table's single read
// port and the shared compare unit; it can stop before the last entry, and a bad magic or
// an empty node skips the scan. Its result is on rsp as done goes high for exactly one
// cycle; the receiver cannot stall,
// so it must take every result as it appears. A new command may transfer in that cycle.
module extent_map_lookup #(
	parameter int MaxEntries = emap_pkg::MAX_ENTRIES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  emap_pkg::req_t req,
	output logic           done,
	output emap_pkg::rsp_t rsp
);
	import emap_pkg::*;

	localparam int AW = $clog2(MaxEntries);
	localparam int CW = $clog2(MaxEntries + 1);
	localparam int XW = (AW > 9) ? AW : 9;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t      state_q;
	logic [15:0] magic_q;
	logic [CW-1:0] count_q;
	logic [15:0] depth_q;
	logic [31:0] query_q;
	logic [AW-1:0] chk_q;
	logic        have_q;
	logic [47:0] best_q;
	logic [47:0] base_q;
	logic [31:0] off_q;
	logic        found_q;
	logic        child_q;
	logic        done_q;
	rsp_t        rsp_q;

	logic        accept;
	logic        we;
	logic [XW-1:0] slot_x;
	logic [AW-1:0] raddr;
	entry_t      wdata;
	entry_t      rdata;
	cmp_t        cmp;
	logic        last;
	logic [CW-1:0] hdr_count_sat;

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp = rsp_q;

	assign slot_x = XW'(req.slot);
	assign we = accept && (req.cmd == CMD_LOAD_ENTRY)
		&& ({23'd0, req.slot} < 32'(MaxEntries));
	assign wdata = '{first: req.entry_first, len: req.entry_len, target: req.entry_target};
	assign raddr = (state_q == ST_SCAN) ? AW'(chk_q + 1'b1) : '0;
	assign last = (CW'(chk_q) + 1'b1) == count_q;
	assign hdr_count_sat = ({16'd0, req.hdr_count} > 32'(MaxEntries))
		? CW'(MaxEntries) : CW'(req.hdr_count);

	emap_table #(
		.MaxEntries(MaxEntries)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(slot_x[AW-1:0]),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	emap_cmp u_cmp (
		.entry(rdata),
		.query(query_q),
		.res  (cmp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			magic_q <= '0;
			count_q <= '0;
			depth_q <= '0;
			done_q <= 1'b0;
			chk_q <= '0;
			have_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && req.cmd == CMD_LOAD_HDR) begin
						magic_q <= req.hdr_magic;
						count_q <= hdr_count_sat;
						depth_q <= req.hdr_depth;
					end else if (accept && req.cmd == CMD_LOOKUP) begin
						query_q <= req.query_block;
						chk_q <= '0;
						have_q <= 1'b0;
						base_q <= '0;
						off_q <= '0;
						found_q <= 1'b0;
						child_q <= 1'b0;
						if (magic_q != NODE_MAGIC_OK || count_q == '0) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (depth_q == '0) begin
						if (cmp.leaf_hit) begin
							base_q <= rdata.target;
							off_q <= cmp.offset;
							found_q <= 1'b1;
							state_q <= ST_FINISH;
						end else if (last) begin
							state_q <= ST_FINISH;
						end else begin
							chk_q <= chk_q + 1'b1;
						end
					end else begin
						// Index node: the answer is the last entry not above the query.
						if (cmp.past) begin
							base_q <= have_q ? best_q : '0;
							found_q <= have_q;
							child_q <= have_q;
							state_q <= ST_FINISH;
						end else if (last) begin
							base_q <= rdata.target;
							found_q <= 1'b1;
							child_q <= 1'b1;
							state_q <= ST_FINISH;
						end else begin
							have_q <= 1'b1;
							best_q <= rdata.target;
							chk_q <= chk_q + 1'b1;
						end
					end
				end
				ST_FINISH: begin
					done_q <= 1'b1;
					rsp_q.mapped_block <= {1'b0, base_q} + {17'd0, off_q};
					rsp_q.found <= found_q;
					rsp_q.is_child <= child_q;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
